// ===== design/cges_pkg.sv =====
// Package: shared types, register codes, reset values and fixed-point helpers.
`timescale 1ns / 1ps
package cges_pkg;

  localparam int unsigned QW = 48;   // Q24.24 word
  localparam int unsigned PW = 96;   // full product / radicand width
  localparam int unsigned GW = 47;   // grav_param width
  localparam int unsigned DW = 24;   // step_size width
  localparam int unsigned IW = 3;    // register index width

  typedef logic signed [QW-1:0] q_t;

  // Configuration register codes
  typedef enum logic [IW-1:0] {
    REG_GRAV_PARAM = 3'd0,
    REG_STEP_SIZE  = 3'd1,
    REG_INIT_X     = 3'd2,
    REG_INIT_Y     = 3'd3,
    REG_INIT_Z     = 3'd4,
    REG_INIT_VX    = 3'd5,
    REG_INIT_VY    = 3'd6,
    REG_INIT_VZ    = 3'd7
  } cfg_reg_t;

  localparam logic [GW-1:0] RST_GRAV_PARAM = 47'd16777216;
  localparam logic [DW-1:0] RST_STEP_SIZE  = 24'd16777;
  localparam q_t RST_INIT_X  = 48'sd167772160;
  localparam q_t RST_INIT_Y  = 48'sd0;
  localparam q_t RST_INIT_Z  = 48'sd0;
  localparam q_t RST_INIT_VX = 48'sd0;
  localparam q_t RST_INIT_VY = 48'sd2652698;
  localparam q_t RST_INIT_VZ = 48'sd0;

  localparam q_t Q_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam q_t Q_MIN = 48'sh8000_0000_0000;
  localparam logic [QW-1:0] QUO_SAT = 48'h7FFF_FFFF_FFFF;

  // Command to the shift-subtract unit
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ssu_cmd_t;

  // Magnitude of a signed word (most negative value maps to 2^47)
  function automatic logic [QW-1:0] abs_q(input q_t v);
    logic [QW-1:0] m;
    m = v[QW-1] ? (~v + 48'd1) : v;
    return m;
  endfunction

  // floor(+-p / 2^24) with saturation; neg gives the sign of the product
  function automatic q_t mulq_fix(input logic neg, input logic [PW-1:0] p);
    logic [QW-1:0] q;
    logic          ovf;
    logic [QW:0]   qc;
    logic [QW:0]   nq;
    q_t            res;
    q   = p[71:24];
    ovf = |p[PW-1:72];
    qc  = {1'b0, q} + {48'd0, |p[23:0]};
    nq  = ~qc + 49'd1;
    if (neg) begin
      if (ovf || qc > 49'h0_8000_0000_0000) res = Q_MIN;
      else res = nq[QW-1:0];
    end else begin
      if (ovf || q[QW-1]) res = Q_MAX;
      else res = q;
    end
    return res;
  endfunction

  // Saturating a + b
  function automatic q_t sat_add(input q_t a, input q_t b);
    logic [QW:0] s;
    q_t          res;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) res = s[QW] ? Q_MIN : Q_MAX;
    else res = s[QW-1:0];
    return res;
  endfunction

  // Saturating a - b
  function automatic q_t sat_sub(input q_t a, input q_t b);
    logic [QW:0] s;
    q_t          res;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) res = s[QW] ? Q_MIN : Q_MAX;
    else res = s[QW-1:0];
    return res;
  endfunction

endpackage

// ===== design/cges_if.sv =====
// Stream interfaces: tick input channel and position result channel.
`timescale 1ns / 1ps
interface cges_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cges_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [47:0]   pos_x;
  logic signed [47:0]   pos_y;
  logic signed [47:0]   pos_z;
  logic                 at_origin;
  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output at_origin, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input at_origin, output ready);
endinterface

// ===== design/cges_mul.sv =====
// Iterative 48x48 unsigned multiplier: one 24x24 partial product per cycle.
`timescale 1ns / 1ps
module cges_mul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [cges_pkg::QW-1:0]  a,
  input  logic [cges_pkg::QW-1:0]  b,
  output logic                     done,
  output logic [cges_pkg::PW-1:0]  prod
);

  logic [cges_pkg::QW-1:0] a_r, b_r;
  logic [cges_pkg::PW-1:0] acc_r;
  logic [1:0]              cnt_r;
  logic                    run_r, done_r;
  logic [23:0]             ah, bh;
  logic [47:0]             pp;
  logic [1:0]              sh;
  logic [cges_pkg::PW-1:0] pp_sh;

  // select halves; cnt bit 1 picks a, bit 0 picks b
  assign ah = cnt_r[1] ? a_r[47:24] : a_r[23:0];
  assign bh = cnt_r[0] ? b_r[47:24] : b_r[23:0];
  assign pp = ah * bh;
  assign sh = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};

  always_comb begin
    case (sh)
      2'd0:    pp_sh = {48'd0, pp};
      2'd1:    pp_sh = {24'd0, pp, 24'd0};
      2'd2:    pp_sh = {pp, 48'd0};
      default: pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses the cycle after the last partial product
      done_r <= !start && run_r && (cnt_r == 2'd3);
      if (start) begin
        a_r   <= a;
        b_r   <= b;
        acc_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        acc_r <= acc_r + pp_sh;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) run_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== design/cges_shsub.sv =====
// Shift-subtract unit: bitwise square root or Q24.24 fractional divide.
`timescale 1ns / 1ps
module cges_shsub (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cges_pkg::ssu_cmd_t       cmd,
  input  logic [cges_pkg::PW-1:0]  rad,     // radicand, or dividend in low 48 bits
  input  logic [cges_pkg::QW-1:0]  den,     // divisor, nonzero
  output logic                     done,
  output logic [cges_pkg::QW-1:0]  result
);

  logic [51:0]             rem_r;
  logic [cges_pkg::QW-1:0] acc_r;
  logic [cges_pkg::PW-1:0] src_r;
  logic [5:0]              cnt_r;
  logic                    run_r, done_r, sqrt_r;
  logic [51:0]             cand, trial, diff;
  logic                    ge;
  logic                    div_sat;

  // sqrt brings in two radicand bits, divide one dividend bit
  assign cand  = sqrt_r ? {rem_r[49:0], src_r[95:94]} : {rem_r[50:0], src_r[95]};
  assign trial = sqrt_r ? {2'b00, acc_r, 2'b01} : {4'd0, den};
  assign ge    = cand >= trial;
  assign diff  = cand - trial;

  // quotient would reach 2^47: a >= d * 2^23
  assign div_sat = {24'd0, rad[47:0]} >= {1'b0, den, 23'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done on a saturated divide, or after the last iteration
      done_r <= (cmd.start && !cmd.is_sqrt && div_sat) ||
                (!cmd.start && run_r && (cnt_r == 6'd1));
      if (cmd.start) begin
        sqrt_r <= cmd.is_sqrt;
        if (cmd.is_sqrt) begin
          acc_r <= '0;
          rem_r <= '0;
          src_r <= rad;
          cnt_r <= 6'd48;
          run_r <= 1'b1;
        end else if (div_sat) begin
          acc_r <= cges_pkg::QUO_SAT;
        end else begin
          // integer part of a/d is below 2^23 so only 47 quotient bits remain
          acc_r <= '0;
          rem_r <= {27'd0, rad[47:23]};
          src_r <= {rad[22:0], 73'd0};
          cnt_r <= 6'd47;
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        rem_r <= ge ? diff : cand;
        acc_r <= {acc_r[46:0], ge};
        src_r <= sqrt_r ? {src_r[93:0], 2'b00} : {src_r[94:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) run_r <= 1'b0;
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

// ===== design/central_gravity_euler_step_unit.sv =====
// Top level: Euler step sequencer around a shared multiplier and root/divide unit.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+--------------------------------------
//  in_ch   | in  | valid / ready    | restart
//  out_ch  | out | valid / ready    | pos_x, pos_y, pos_z, at_origin
//  cfg     | in  | cfg_we           | cfg_index (3b), cfg_data (48b)
//
// In a normal tick the root and three divides run one bit a cycle in the
// shift-subtract unit; the squares and nine update products run on the
// 48x48 multiplier, which is built from 24x24 partial products. A tick at
// zero distance skips the root, the divides and the velocity products.
// in_ch.ready is high only while the sequencer is idle; the result leaves as
// soon as the squares are summed and waits in the output register under stall.
// Reset (synchronous, active low) loads register and state reset values.
`timescale 1ns / 1ps
module central_gravity_euler_step_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [cges_pkg::IW-1:0]  cfg_index,
  input  logic [cges_pkg::QW-1:0]  cfg_data,
  cges_in_if.sink                  in_ch,
  cges_out_if.source               out_ch
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SQ   = 8'b0000_0010,
    ST_EMIT = 8'b0000_0100,
    ST_ROOT = 8'b0000_1000,
    ST_DIV  = 8'b0001_0000,
    ST_MPK  = 8'b0010_0000,
    ST_MKD  = 8'b0100_0000,
    ST_MVD  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [cges_pkg::GW-1:0] gm_r;
  logic [cges_pkg::DW-1:0] dt_r;
  cges_pkg::q_t            ipos_r [3];
  cges_pkg::q_t            ivel_r [3];

  // body state and working registers
  cges_pkg::q_t            pos_r [3];
  cges_pkg::q_t            vel_r [3];
  logic [cges_pkg::PW-1:0] sum_r;
  logic [cges_pkg::QW-1:0] root_r;
  logic [cges_pkg::QW-1:0] quo_r;
  cges_pkg::q_t            t_r;
  logic [1:0]              ax_r;
  logic [1:0]              dcnt_r;
  logic                    origin_r, restart_r, launched_r;

  // result register
  logic                    out_valid_r;
  cges_pkg::q_t            out_pos_r [3];
  logic                    out_org_r;

  // unit hookups
  logic                    mul_start, mul_done;
  logic [cges_pkg::QW-1:0] mul_a, mul_b;
  logic [cges_pkg::PW-1:0] mul_prod;
  cges_pkg::ssu_cmd_t      ssu_cmd;
  logic                    ssu_done;
  logic [cges_pkg::QW-1:0] ssu_res;
  logic [cges_pkg::PW-1:0] ssu_rad;

  logic in_xact, slot_free, unit_done;
  logic is_mul_st, is_ssu_st;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xact     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign is_mul_st = (state_r == ST_SQ) || (state_r == ST_MPK) ||
                     (state_r == ST_MKD) || (state_r == ST_MVD);
  assign is_ssu_st = (state_r == ST_ROOT) || (state_r == ST_DIV);
  assign mul_start = is_mul_st && !launched_r;
  assign unit_done = is_mul_st ? mul_done : ssu_done;

  assign ssu_cmd.start   = is_ssu_st && !launched_r;
  assign ssu_cmd.is_sqrt = (state_r == ST_ROOT);
  assign ssu_rad = (state_r == ST_ROOT) ? sum_r : {48'd0, quo_r};

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ: begin
        mul_a = cges_pkg::abs_q(pos_r[ax_r]);
        mul_b = cges_pkg::abs_q(pos_r[ax_r]);
      end
      ST_MPK: begin
        mul_a = cges_pkg::abs_q(pos_r[ax_r]);
        mul_b = quo_r;
      end
      ST_MKD: begin
        mul_a = cges_pkg::abs_q(t_r);
        mul_b = {24'd0, dt_r};
      end
      ST_MVD: begin
        mul_a = cges_pkg::abs_q(vel_r[ax_r]);
        mul_b = {24'd0, dt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cges_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  cges_shsub u_shsub (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (ssu_cmd),
    .rad    (ssu_rad),
    .den    (root_r),
    .done   (ssu_done),
    .result (ssu_res)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xact) state_nxt = in_ch.restart ? ST_EMIT : ST_SQ;
      ST_SQ:   if (mul_done && ax_r == 2'd2) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          if (restart_r) state_nxt = ST_IDLE;
          else if (sum_r == '0) state_nxt = ST_MVD;
          else state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: if (ssu_done) state_nxt = ST_DIV;
      ST_DIV:  if (ssu_done && dcnt_r == 2'd2) state_nxt = ST_MPK;
      ST_MPK:  if (mul_done) state_nxt = ST_MKD;
      ST_MKD:  if (mul_done) state_nxt = ST_MVD;
      ST_MVD: begin
        if (mul_done) begin
          if (ax_r == 2'd2) state_nxt = ST_IDLE;
          else state_nxt = origin_r ? ST_MVD : ST_MPK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ax_r        <= '0;
      dcnt_r      <= '0;
      restart_r   <= 1'b0;
      origin_r    <= 1'b0;
      gm_r        <= cges_pkg::RST_GRAV_PARAM;
      dt_r        <= cges_pkg::RST_STEP_SIZE;
      ipos_r[0]   <= cges_pkg::RST_INIT_X;
      ipos_r[1]   <= cges_pkg::RST_INIT_Y;
      ipos_r[2]   <= cges_pkg::RST_INIT_Z;
      ivel_r[0]   <= cges_pkg::RST_INIT_VX;
      ivel_r[1]   <= cges_pkg::RST_INIT_VY;
      ivel_r[2]   <= cges_pkg::RST_INIT_VZ;
      pos_r[0]    <= cges_pkg::RST_INIT_X;
      pos_r[1]    <= cges_pkg::RST_INIT_Y;
      pos_r[2]    <= cges_pkg::RST_INIT_Z;
      vel_r[0]    <= cges_pkg::RST_INIT_VX;
      vel_r[1]    <= cges_pkg::RST_INIT_VY;
      vel_r[2]    <= cges_pkg::RST_INIT_VZ;
    end else begin
      state_r <= state_nxt;

      // unit launch tracking
      if (mul_start || ssu_cmd.start) launched_r <= 1'b1;
      else if (unit_done) launched_r <= 1'b0;

      // result channel: load on emit, clear on handoff
      if (state_r == ST_EMIT && slot_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      // configuration decode
      if (cfg_we) begin
        unique case (cges_pkg::cfg_reg_t'(cfg_index))
          cges_pkg::REG_GRAV_PARAM: gm_r      <= cfg_data[cges_pkg::GW-1:0];
          cges_pkg::REG_STEP_SIZE:  dt_r      <= cfg_data[cges_pkg::DW-1:0];
          cges_pkg::REG_INIT_X:     ipos_r[0] <= cfg_data;
          cges_pkg::REG_INIT_Y:     ipos_r[1] <= cfg_data;
          cges_pkg::REG_INIT_Z:     ipos_r[2] <= cfg_data;
          cges_pkg::REG_INIT_VX:    ivel_r[0] <= cfg_data;
          cges_pkg::REG_INIT_VY:    ivel_r[1] <= cfg_data;
          cges_pkg::REG_INIT_VZ:    ivel_r[2] <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_xact) begin
            restart_r <= in_ch.restart;
            sum_r     <= '0;
            ax_r      <= '0;
            if (in_ch.restart) begin
              for (int i = 0; i < 3; i++) begin
                pos_r[i] <= ipos_r[i];
                vel_r[i] <= ivel_r[i];
              end
            end
          end
        end
        ST_SQ: begin
          if (mul_done) begin
            sum_r <= sum_r + mul_prod;
            ax_r  <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            for (int i = 0; i < 3; i++) out_pos_r[i] <= pos_r[i];
            out_org_r <= !restart_r && (sum_r == '0);
            origin_r  <= (sum_r == '0);
            quo_r     <= {1'b0, gm_r};
            dcnt_r    <= '0;
          end
        end
        ST_ROOT: if (ssu_done) root_r <= ssu_res;
        ST_DIV: begin
          if (ssu_done) begin
            quo_r  <= ssu_res;
            dcnt_r <= dcnt_r + 2'd1;
          end
        end
        ST_MPK: if (mul_done) t_r <= cges_pkg::mulq_fix(pos_r[ax_r][47], mul_prod);
        ST_MKD: if (mul_done) t_r <= cges_pkg::mulq_fix(t_r[47], mul_prod);
        ST_MVD: begin
          // write back both old-value updates for this axis
          if (mul_done) begin
            pos_r[ax_r] <= cges_pkg::sat_add(pos_r[ax_r],
                             cges_pkg::mulq_fix(vel_r[ax_r][47], mul_prod));
            if (!origin_r) vel_r[ax_r] <= cges_pkg::sat_sub(vel_r[ax_r], t_r);
            ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pos_x     = out_pos_r[0];
  assign out_ch.pos_y     = out_pos_r[1];
  assign out_ch.pos_z     = out_pos_r[2];
  assign out_ch.at_origin = out_org_r;

endmodule

// ===== design/cges_checker.sv =====
// Port checker for the Euler step unit, bound to the top level.
`timescale 1ns / 1ps
module cges_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_restart,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_pos_x,
  input logic        out_at_origin
);

  // result held under stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pos_x) && $stable(out_at_origin))
    else $error("result payload changed while stalled");

  // one tick in flight at a time
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second tick accepted while busy");

  // restart reports at once with the flag clear
  a_restart_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart && !out_valid |-> ##2
      (out_valid && !out_at_origin))
    else $error("restart tick result missing or flagged");

endmodule

bind central_gravity_euler_step_unit cges_checker u_cges_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_restart    (in_ch.restart),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_pos_x     (out_ch.pos_x),
  .out_at_origin (out_ch.at_origin)
);

// ===== dv/testbench.sv =====
// Testbench: drives ticks and register writes into the Euler step unit, checks every position.
`timescale 1ns / 1ps
module testbench;

  localparam int SETTLE    = 400;   // cycles for a tick that is still in flight
  localparam int STALL_MAX = 6000;  // cycles with no transaction before giving up
  localparam int HOLD_LEN  = 300;   // long receiver hold-off

  typedef struct {
    cges_pkg::q_t x;
    cges_pkg::q_t y;
    cges_pkg::q_t z;
    logic         org;
  } body_pos_t;

  typedef struct {
    logic               is_write;
    cges_pkg::cfg_reg_t idx;
    logic [47:0]        data;
    logic               restart;
    logic               typed;
    body_pos_t          want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [cges_pkg::IW-1:0] cfg_index;
  logic [cges_pkg::QW-1:0] cfg_data;

  cges_in_if  in_ch ();
  cges_out_if out_ch ();

  central_gravity_euler_step_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state: register copy, position and velocity
  logic [47:0]  reg_val [8];
  cges_pkg::q_t orbit_pos [3];
  cges_pkg::q_t orbit_vel [3];
  body_pos_t    pending_pos [$];
  stim_row_t    directed [$];

  int  errors;
  int  n_ticks, n_restarts, n_origin, n_results, n_writes;
  bit  quiet;
  bit  hold_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(a*b / 2^24) with a signed, b unsigned, clamped to 48 bits signed
  function automatic cges_pkg::q_t scaled_mul(input cges_pkg::q_t a, input logic [47:0] b);
    logic [48:0] mag;
    logic [96:0] prod;
    logic [48:0] q;
    mag  = a[47] ? (49'd0 - {1'b1, a}) : {1'b0, a};
    prod = {48'd0, mag} * {49'd0, b};
    if (|prod[96:72]) return a[47] ? cges_pkg::Q_MIN : cges_pkg::Q_MAX;
    q = {1'b0, prod[71:24]};
    if (a[47]) begin
      q = q + {48'd0, |prod[23:0]};
      if (q > 49'h0_8000_0000_0000) return cges_pkg::Q_MIN;
      return cges_pkg::q_t'(48'd0 - q[47:0]);
    end
    if (q[47]) return cges_pkg::Q_MAX;
    return cges_pkg::q_t'(q[47:0]);
  endfunction

  // floor(a*2^24 / d) clamped to 2^47-1
  function automatic logic [47:0] scaled_div(input logic [47:0] a, input logic [48:0] d);
    logic [71:0] quo;
    if ({24'd0, a} / {23'd0, d} >= 72'd8388608) return 48'h7FFF_FFFF_FFFF;
    quo = {a, 24'd0} / {23'd0, d};
    return quo[47:0];
  endfunction

  // Clamped signed add or subtract
  function automatic cges_pkg::q_t clamp_sum(input cges_pkg::q_t a, input cges_pkg::q_t b,
                                             input logic sub);
    logic signed [48:0] s;
    s = sub ? ($signed({a[47], a}) - $signed({b[47], b}))
            : ($signed({a[47], a}) + $signed({b[47], b}));
    if (s > 49'sh0_7FFF_FFFF_FFFF) return cges_pkg::Q_MAX;
    if (s < -49'sh0_8000_0000_0000) return cges_pkg::Q_MIN;
    return s[47:0];
  endfunction

  function automatic void load_orbit();
    for (int i = 0; i < 3; i++) begin
      orbit_pos[i] = reg_val[cges_pkg::REG_INIT_X + i];
      orbit_vel[i] = reg_val[cges_pkg::REG_INIT_VX + i];
    end
  endfunction

  // One tick of the orbit; returns the position that the block reports
  function automatic body_pos_t orbit_tick(input logic restart);
    body_pos_t    res;
    logic [97:0]  rad2;
    logic [97:0]  cc;
    logic [48:0]  mag;
    logic [48:0]  root_est;
    logic [48:0]  cand;
    logic [47:0]  kk;
    logic [47:0]  dt;
    cges_pkg::q_t p;
    cges_pkg::q_t v;
    if (restart) load_orbit();
    res.x = orbit_pos[0];
    res.y = orbit_pos[1];
    res.z = orbit_pos[2];
    res.org = 1'b0;
    if (restart) return res;
    rad2 = '0;
    for (int i = 0; i < 3; i++) begin
      mag  = orbit_pos[i][47] ? (49'd0 - {1'b1, orbit_pos[i]}) : {1'b0, orbit_pos[i]};
      rad2 = rad2 + {49'd0, mag} * {49'd0, mag};
    end
    res.org = (rad2 == '0);
    kk = '0;
    if (!res.org) begin
      // bitwise integer square root
      root_est = '0;
      for (int b = 48; b >= 0; b--) begin
        cand = root_est | (49'd1 << b);
        cc   = {49'd0, cand} * {49'd0, cand};
        if (cc <= rad2) root_est = cand;
      end
      kk = scaled_div(scaled_div(scaled_div(reg_val[cges_pkg::REG_GRAV_PARAM], root_est),
                                 root_est), root_est);
    end
    dt = {24'd0, reg_val[cges_pkg::REG_STEP_SIZE][23:0]};
    for (int i = 0; i < 3; i++) begin
      p = orbit_pos[i];
      v = orbit_vel[i];
      orbit_pos[i] = clamp_sum(p, scaled_mul(v, dt), 1'b0);
      if (!res.org) orbit_vel[i] = clamp_sum(v, scaled_mul(scaled_mul(p, kk), dt), 1'b1);
    end
    return res;
  endfunction

  task automatic report(input string what, input cges_pkg::q_t got, input cges_pkg::q_t want);
    errors++;
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_results);
  endtask

  // Wait until every result is back, then let a last tick finish inside
  task automatic drain_wait();
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write; caller lowers cfg_we with cfg_release
  task automatic reg_write(input cges_pkg::cfg_reg_t idx, input logic [47:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      cges_pkg::REG_GRAV_PARAM: reg_val[idx] = {1'b0, data[46:0]};
      cges_pkg::REG_STEP_SIZE:  reg_val[idx] = {24'd0, data[23:0]};
      default:                  reg_val[idx] = data;
    endcase
    n_writes++;
  endtask

  task automatic cfg_release();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one tick; predicted on acceptance, typed value used when given
  task automatic send_tick(input logic restart, input logic typed, input body_pos_t want);
    body_pos_t pred;
    while (!quiet && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    pred = orbit_tick(restart);
    pending_pos.push_back(typed ? want : pred);
    if (restart) n_restarts++;
    else n_ticks++;
  endtask

  // Random register value: extremes, zero, full range or a plausible orbit
  function automatic logic [47:0] pick_value(input cges_pkg::cfg_reg_t idx);
    logic [47:0] full;
    int          mode;
    full = {$urandom(), $urandom()};
    mode = $urandom_range(0, 7);
    case (mode)
      0: return 48'd0;
      1: return 48'hFFFF_FFFF_FFFF;
      2: return 48'h7FFF_FFFF_FFFF;
      3: return 48'h8000_0000_0000;
      4: return full;
      default: begin
        case (idx)
          cges_pkg::REG_GRAV_PARAM: return 48'($urandom_range(1, 200)) << 24;
          cges_pkg::REG_STEP_SIZE:  return 48'($urandom_range(1, 1 << 20));
          cges_pkg::REG_INIT_X, cges_pkg::REG_INIT_Y, cges_pkg::REG_INIT_Z:
            return 48'($urandom_range(0, 40 << 24)) - (48'd20 << 24);
          default:
            return 48'($urandom_range(0, 8 << 24)) - (48'd4 << 24);
        endcase
      end
    endcase
  endfunction

  function automatic void add_write(input cges_pkg::cfg_reg_t idx, input logic [47:0] data);
    stim_row_t r;
    r = '{1'b1, idx, data, 1'b0, 1'b0, '{'0, '0, '0, 1'b0}};
    directed.push_back(r);
  endfunction

  function automatic void add_tick(input logic restart, input logic typed,
                                   input cges_pkg::q_t x, input cges_pkg::q_t y,
                                   input cges_pkg::q_t z, input logic org);
    stim_row_t r;
    r = '{1'b0, cges_pkg::REG_GRAV_PARAM, '0, restart, typed, '{x, y, z, org}};
    directed.push_back(r);
  endfunction

  // Result side: check each transaction, then drive ready
  initial begin
    body_pos_t want;
    int        hold_cnt;
    hold_cnt = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        n_results++;
        if (pending_pos.size() == 0) begin
          report("unexpected result", out_ch.pos_x, '0);
        end else begin
          want = pending_pos.pop_front();
          if (out_ch.pos_x !== want.x) report("pos_x", out_ch.pos_x, want.x);
          if (out_ch.pos_y !== want.y) report("pos_y", out_ch.pos_y, want.y);
          if (out_ch.pos_z !== want.z) report("pos_z", out_ch.pos_z, want.z);
          if (out_ch.at_origin !== want.org)
            report("at_origin", cges_pkg::q_t'(out_ch.at_origin), cges_pkg::q_t'(want.org));
          if (want.org) n_origin++;
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n && (quiet || $urandom_range(0, 99) >= 33);
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transaction
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    while (idle_cnt < STALL_MAX) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt = 0;
      else idle_cnt++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_MAX);
    $display("testbench: FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    int n_phase;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    errors = 0;
    n_ticks = 0; n_restarts = 0; n_origin = 0; n_results = 0; n_writes = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    reg_val[cges_pkg::REG_GRAV_PARAM] = {1'b0, cges_pkg::RST_GRAV_PARAM};
    reg_val[cges_pkg::REG_STEP_SIZE]  = {24'd0, cges_pkg::RST_STEP_SIZE};
    reg_val[cges_pkg::REG_INIT_X]  = cges_pkg::RST_INIT_X;
    reg_val[cges_pkg::REG_INIT_Y]  = cges_pkg::RST_INIT_Y;
    reg_val[cges_pkg::REG_INIT_Z]  = cges_pkg::RST_INIT_Z;
    reg_val[cges_pkg::REG_INIT_VX] = cges_pkg::RST_INIT_VX;
    reg_val[cges_pkg::REG_INIT_VY] = cges_pkg::RST_INIT_VY;
    reg_val[cges_pkg::REG_INIT_VZ] = cges_pkg::RST_INIT_VZ;
    load_orbit();

    // Directed table: reset state, restart, zero distance, extremes, tiny radius, zero dt
    add_tick(1'b0, 1'b1, cges_pkg::RST_INIT_X, cges_pkg::RST_INIT_Y, cges_pkg::RST_INIT_Z,
             1'b0);
    add_tick(1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_tick(1'b1, 1'b1, cges_pkg::RST_INIT_X, cges_pkg::RST_INIT_Y, cges_pkg::RST_INIT_Z,
             1'b0);
    add_write(cges_pkg::REG_INIT_X, 48'd0);
    add_write(cges_pkg::REG_INIT_VX, 48'd1 << 24);
    add_tick(1'b1, 1'b1, '0, '0, '0, 1'b0);
    add_tick(1'b0, 1'b1, '0, '0, '0, 1'b1);
    add_tick(1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_write(cges_pkg::REG_GRAV_PARAM, 48'hFFFF_FFFF_FFFF);
    add_write(cges_pkg::REG_STEP_SIZE, 48'hFFFF_FFFF_FFFF);
    add_write(cges_pkg::REG_INIT_X, cges_pkg::Q_MAX);
    add_write(cges_pkg::REG_INIT_Y, cges_pkg::Q_MIN);
    add_write(cges_pkg::REG_INIT_Z, cges_pkg::Q_MAX);
    add_write(cges_pkg::REG_INIT_VX, cges_pkg::Q_MAX);
    add_write(cges_pkg::REG_INIT_VY, cges_pkg::Q_MIN);
    add_write(cges_pkg::REG_INIT_VZ, cges_pkg::Q_MIN);
    add_tick(1'b1, 1'b1, cges_pkg::Q_MAX, cges_pkg::Q_MIN, cges_pkg::Q_MAX, 1'b0);
    add_tick(1'b0, 1'b1, cges_pkg::Q_MAX, cges_pkg::Q_MIN, cges_pkg::Q_MAX, 1'b0);
    add_tick(1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_write(cges_pkg::REG_INIT_X, 48'd1);
    add_write(cges_pkg::REG_INIT_Y, 48'd0);
    add_write(cges_pkg::REG_INIT_Z, 48'd0);
    add_tick(1'b1, 1'b1, 48'sd1, '0, '0, 1'b0);
    add_tick(1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_write(cges_pkg::REG_STEP_SIZE, 48'd0);
    add_write(cges_pkg::REG_GRAV_PARAM, 48'd0);
    add_tick(1'b1, 1'b1, 48'sd1, '0, '0, 1'b0);
    add_tick(1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_tick(1'b0, 1'b0, '0, '0, '0, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_write) begin
        if (i == 0 || !directed[i-1].is_write) begin
          in_ch.valid <= 1'b0;
          drain_wait();
        end
        reg_write(directed[i].idx, directed[i].data);
        if (!directed[i+1].is_write) cfg_release();
      end else begin
        send_tick(directed[i].restart, directed[i].typed, directed[i].want);
      end
    end

    // Random phases: new settings, a restart, then a run of ticks
    for (n_phase = 0; n_phase < 8; n_phase++) begin
      in_ch.valid <= 1'b0;
      drain_wait();
      for (int r = 0; r < 8; r++)
        if ($urandom_range(0, 2) != 0)
          reg_write(cges_pkg::cfg_reg_t'(r), pick_value(cges_pkg::cfg_reg_t'(r)));
      cfg_release();
      quiet = (n_phase == 2);
      send_tick(1'b1, 1'b0, '{'0, '0, '0, 1'b0});
      for (int k = 0; k < 72; k++) begin
        if (n_phase == 4 && k == 10) hold_req = 1'b1;
        if (n_phase == 5 && k == 30) begin
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (pending_pos.size() != 0);
        end
        send_tick($urandom_range(0, 99) < 8, 1'b0, '{'0, '0, '0, 1'b0});
      end
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;
    drain_wait();

    $display("covered %0d steps, %0d restarts, %0d zero-distance results, %0d register writes",
             n_ticks, n_restarts, n_origin, n_writes);
    $display("%0d results checked across directed extremes and 8 random setting phases",
             n_results);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
